// File: design/rrmb_pkg.sv
// Shared types and constants for the rectangle row to mono byte writer
package rrmb_pkg;

   // full-width frame byte address, wide enough for the frame size compare
   localparam int ADDR_W = 18;

   // pixel masks, bit 7 is the leftmost pixel
   localparam logic [7:0] MASK_ALL   = 8'hFF;
   localparam logic [7:0] MASK_LEFT  = 8'h80;
   localparam logic [7:0] MASK_RIGHT = 8'h01;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   // one row job handed from the front to the back
   typedef struct packed {
      logic [ADDR_W-1:0] start_addr;
      logic [ADDR_W-1:0] end_addr;
      logic [7:0]        first_mask;
      logic [7:0]        last_mask;
      logic              skip_middle;
      logic              invert;
   } rrmb_cmd_type;

endpackage

// File: design/rrmb_front.sv
// Front end: accepts row requests, drops empty rows, computes addresses and edge masks
module rrmb_front #(
   parameter int SCREEN_WIDTH = 320
) (
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [47:0]           req_tdata,
   input  logic [1:0]            req_tuser,
   output logic                  push,
   output rrmb_pkg::rrmb_cmd_type push_cmd,
   input  logic                  queue_full
);

   localparam logic [10:0] SCREEN_W_V  = 11'(SCREEN_WIDTH);
   localparam logic [15:0] ROW_BYTES_V = 16'(SCREEN_WIDTH / 8);

   logic [16:0] start_pixel;
   logic [8:0]  span_length;
   logic [7:0]  rect_height;
   logic [7:0]  row_index;
   logic        solid_fill;
   logic        invert;

   logic [10:0] span_sat;
   logic [17:0] end_pixel;
   logic [2:0]  so;
   logic [2:0]  eo;
   logic [15:0] base;
   logic [rrmb_pkg::ADDR_W-1:0] start_addr;
   logic [rrmb_pkg::ADDR_W-1:0] end_addr;
   logic        row_ok;
   logic        full_row;
   logic        single;
   logic [7:0]  fill_left;
   logic [7:0]  fill_right;
   logic [7:0]  edge_left;
   logic [7:0]  edge_right;
   logic [7:0]  single_mask;

   // unpack request fields
   assign start_pixel = req_tdata[16:0];
   assign span_length = req_tdata[25:17];
   assign rect_height = req_tdata[33:26];
   assign row_index   = req_tdata[41:34];
   assign solid_fill  = req_tuser[0];
   assign invert      = req_tuser[1];

   // span clamp and end pixel
   always_comb begin
      if ({2'b00, span_length} > SCREEN_W_V) begin
         span_sat = SCREEN_W_V;
      end else begin
         span_sat = {2'b00, span_length};
      end
      end_pixel = {1'b0, start_pixel} + {7'b0, span_sat} - 18'd1;
   end

   assign so = start_pixel[2:0];
   assign eo = end_pixel[2:0];

   // row base and byte addresses
   assign base       = {8'b0, row_index} * ROW_BYTES_V;
   assign start_addr = {4'b0, start_pixel[16:3]} + {2'b0, base};
   assign end_addr   = {3'b0, end_pixel[17:3]} + {2'b0, base};

   // row classification
   assign row_ok   = (span_length != 9'd0) && (rect_height != 8'd0)
                     && (row_index < rect_height);
   assign full_row = solid_fill || (row_index == 8'd0)
                     || (row_index == rect_height - 8'd1);
   assign single   = (start_addr == end_addr);

   // edge masks
   assign fill_left   = rrmb_pkg::MASK_ALL >> so;
   assign fill_right  = rrmb_pkg::MASK_ALL << (~eo);
   assign edge_left   = rrmb_pkg::MASK_LEFT >> so;
   assign edge_right  = rrmb_pkg::MASK_RIGHT << (~eo);
   assign single_mask = full_row ? (fill_left & fill_right) : (edge_left | edge_right);

   // command to the queue
   always_comb begin
      push_cmd.start_addr  = start_addr;
      push_cmd.end_addr    = end_addr;
      push_cmd.skip_middle = !full_row;
      push_cmd.invert      = invert;
      if (single) begin
         push_cmd.first_mask = single_mask;
         push_cmd.last_mask  = single_mask;
      end else begin
         push_cmd.first_mask = full_row ? fill_left : edge_left;
         push_cmd.last_mask  = full_row ? fill_right : edge_right;
      end
   end

   // handshake; empty rows are taken and dropped
   assign req_tready = !reset && !queue_full;
   assign push       = req_tvalid && req_tready && row_ok;

endmodule

// File: design/rrmb_queue.sv
// Small command queue between front and back
module rrmb_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  rrmb_pkg::rrmb_cmd_type push_cmd,
   output logic                   full,
   input  logic                   pop,
   output logic                   pop_valid,
   output rrmb_pkg::rrmb_cmd_type pop_cmd
);

   rrmb_pkg::rrmb_cmd_type entry_ff [rrmb_pkg::QUEUE_DEPTH];
   logic [rrmb_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [rrmb_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [rrmb_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;
   logic do_push;
   logic do_pop;

   assign full      = (count_ff == rrmb_pkg::QUEUE_CNT_W'(rrmb_pkg::QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_cmd   = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   // pointer and count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: design/rrmb_back.sv
// Back end: walks the byte addresses of one row and drives the registered write output
module rrmb_back #(
   parameter int SCREEN_WIDTH  = 320,
   parameter int SCREEN_HEIGHT = 240
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_valid,
   input  rrmb_pkg::rrmb_cmd_type cmd,
   output logic                   cmd_pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [23:0]            rsp_tdata,
   output logic [1:0]             rsp_tuser,
   output logic                   rsp_tlast
);

   localparam logic [rrmb_pkg::ADDR_W-1:0] FRAME_BYTES =
      rrmb_pkg::ADDR_W'((SCREEN_WIDTH / 8) * SCREEN_HEIGHT);

   // active row job
   logic                        busy_ff, busy_in;
   logic                        first_ff, first_in;
   logic [rrmb_pkg::ADDR_W-1:0] cur_ff, cur_in;
   rrmb_pkg::rrmb_cmd_type      job_ff, job_in;

   // output register
   logic        out_valid_ff, out_valid_in;
   logic [13:0] out_addr_ff, out_addr_in;
   logic [7:0]  out_mask_ff, out_mask_in;
   logic        out_inv_ff, out_inv_in;
   logic        out_off_ff, out_off_in;
   logic        out_last_ff, out_last_in;

   logic emit;
   logic at_end;

   assign emit    = busy_ff && (!out_valid_ff || rsp_tready);
   assign at_end  = (cur_ff == job_ff.end_addr);
   assign cmd_pop = !busy_ff && cmd_valid;

   // job walker
   always_comb begin
      busy_in  = busy_ff;
      first_in = first_ff;
      cur_in   = cur_ff;
      job_in   = job_ff;
      if (cmd_pop) begin
         busy_in  = 1'b1;
         first_in = 1'b1;
         cur_in   = cmd.start_addr;
         job_in   = cmd;
      end else if (emit) begin
         first_in = 1'b0;
         if (at_end) begin
            busy_in = 1'b0;
         end else if (job_ff.skip_middle) begin
            cur_in = job_ff.end_addr;
         end else begin
            cur_in = cur_ff + 1'b1;
         end
      end
   end

   // output register next values
   always_comb begin
      out_valid_in = out_valid_ff;
      out_addr_in  = out_addr_ff;
      out_mask_in  = out_mask_ff;
      out_inv_in   = out_inv_ff;
      out_off_in   = out_off_ff;
      out_last_in  = out_last_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_addr_in  = cur_ff[13:0];
         out_inv_in   = job_ff.invert;
         out_off_in   = (cur_ff >= FRAME_BYTES);
         out_last_in  = at_end;
         priority if (at_end) begin
            out_mask_in = job_ff.last_mask;
         end else if (first_ff) begin
            out_mask_in = job_ff.first_mask;
         end else begin
            out_mask_in = rrmb_pkg::MASK_ALL;
         end
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      first_ff    <= first_in;
      cur_ff      <= cur_in;
      job_ff      <= job_in;
      out_addr_ff <= out_addr_in;
      out_mask_ff <= out_mask_in;
      out_inv_ff  <= out_inv_in;
      out_off_ff  <= out_off_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_mask_ff, out_addr_ff};
   assign rsp_tuser  = {out_off_ff, out_inv_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

// File: design/rect_row_to_mono_bytes.sv
// The first byte write of a row passes the command queue, the row job register and
// the output register on its way to rsp. The back end loads a row job, then gives
// one write per cycle while rsp is not stalled, up to 41 writes for the widest row;
// the address walker sets this rate. Requests that draw nothing are taken, with no writes.
// Reset (synchronous, active high) empties the command queue and the output register.
// Top level: rectangle row to 1bpp frame buffer byte writes
module rect_row_to_mono_bytes #(
   parameter int SCREEN_WIDTH  = 320,
   parameter int SCREEN_HEIGHT = 240
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // start_pixel[16:0], span_length[25:17], rect_height[33:26], row_index[41:34], zeros
   input  logic [47:0] req_tdata,
   // solid_fill[0], invert[1]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // byte_address[13:0], pixel_byte[21:14], zeros
   output logic [23:0] rsp_tdata,
   // invert_out[0], off_screen[1]
   output logic [1:0]  rsp_tuser,
   // last_in_row
   output logic        rsp_tlast
);

   logic                   push;
   logic                   queue_full;
   logic                   cmd_valid;
   logic                   cmd_pop;
   rrmb_pkg::rrmb_cmd_type push_cmd;
   rrmb_pkg::rrmb_cmd_type cmd;

   // request classification
   rrmb_front #(
      .SCREEN_WIDTH (SCREEN_WIDTH)
   ) u_front (
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push       (push),
      .push_cmd   (push_cmd),
      .queue_full (queue_full)
   );

   // row job queue
   rrmb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (queue_full),
      .pop       (cmd_pop),
      .pop_valid (cmd_valid),
      .pop_cmd   (cmd)
   );

   // byte write generation
   rrmb_back #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: test/rrmb_checker.sv
// Checker for the rectangle row byte writer: predicts each row's writes and compares
`timescale 1ns / 100ps

module rrmb_checker #(
   parameter int SCREEN_WIDTH  = 320,
   parameter int SCREEN_HEIGHT = 240
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   // start_pixel[16:0], span_length[25:17], rect_height[33:26], row_index[41:34], zeros
   input  logic [47:0] req_tdata,
   // solid_fill[0], invert[1]
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   // byte_address[13:0], pixel_byte[21:14], zeros
   input  logic [23:0] rsp_tdata,
   // invert_out[0], off_screen[1]
   input  logic [1:0]  rsp_tuser,
   input  logic        rsp_tlast,
   output int          fail_count,
   output int          writes_pending
);

   localparam int ROW_BYTES   = SCREEN_WIDTH / 8;
   localparam int FRAME_BYTES = ROW_BYTES * SCREEN_HEIGHT;
   localparam int WRITE_CAP   = 41;
   localparam int PRINT_CAP   = 60;

   // one frame buffer byte write
   typedef struct {
      logic [13:0] addr;
      logic [7:0]  mask;
      logic        inv;
      logic        off;
      logic        last;
   } byte_write_type;

   byte_write_type expected_writes[$];
   int             row_write_count;
   int             mismatches = 0;

   assign fail_count = mismatches;

   // queue one predicted write, dropping anything past the per-row cap
   function automatic void add_write(input int unsigned addr, input logic [7:0] mask,
                                     input logic inv);
      byte_write_type w;
      if (row_write_count >= WRITE_CAP) return;
      w.addr = addr[13:0];
      w.mask = mask;
      w.inv  = inv;
      w.off  = (addr >= FRAME_BYTES);
      w.last = 1'b0;
      expected_writes.push_back(w);
      row_write_count++;
   endfunction

   // byte writes for one rectangle row
   function automatic void predict_row(input logic [16:0] pos, input logic [8:0] span_in,
                                       input logic [7:0] height, input logic [7:0] row,
                                       input logic solid, input logic inv);
      int unsigned p, ht, rw, span, first, last_byte, so, eo, base, x;
      logic [7:0]  head_mask, tail_mask;
      bit          full_row;
      row_write_count = 0;
      // empty rectangle or row outside it draws nothing
      if (span_in == 9'd0 || height == 8'd0 || row >= height) return;
      p    = 32'(pos);
      ht   = 32'(height);
      rw   = 32'(row);
      // spans wider than the screen saturate
      span = 32'(span_in);
      if (span > SCREEN_WIDTH) span = SCREEN_WIDTH;
      first     = p >> 3;
      so        = p & 7;
      last_byte = (p + span - 1) >> 3;
      eo        = (p + span - 1) & 7;
      base      = rw * ROW_BYTES;
      full_row  = solid || rw == 0 || rw == ht - 1;
      head_mask = rrmb_pkg::MASK_ALL >> so;
      tail_mask = rrmb_pkg::MASK_ALL << (7 - eo);
      if (first == last_byte) begin
         // whole row inside one byte
         if (full_row) add_write(first + base, head_mask & tail_mask, inv);
         else add_write(first + base,
                        (rrmb_pkg::MASK_LEFT >> so) | (rrmb_pkg::MASK_LEFT >> eo), inv);
      end else if (full_row) begin
         add_write(first + base, head_mask, inv);
         for (x = first + 1; x < last_byte; x++) add_write(x + base, rrmb_pkg::MASK_ALL, inv);
         add_write(last_byte + base, tail_mask, inv);
      end else begin
         // outline middle row, edge pixels only
         add_write(first + base, rrmb_pkg::MASK_LEFT >> so, inv);
         add_write(last_byte + base, rrmb_pkg::MASK_RIGHT << (7 - eo), inv);
      end
      if (row_write_count > 0) expected_writes[expected_writes.size() - 1].last = 1'b1;
   endfunction

   // one line per mismatch up to PRINT_CAP, every mismatch counted
   task automatic report_mismatch(input string what, input int unsigned got_v,
                                  input int unsigned want_v);
      mismatches++;
      if (mismatches <= PRINT_CAP)
         $display("%0t rrmb: %s got %0h want %0h", $time, what, got_v, want_v);
   endtask

   // compare one accepted write against the oldest prediction
   task automatic check_write();
      byte_write_type want;
      if (expected_writes.size() == 0) begin
         report_mismatch("write with none pending, addr", 32'(rsp_tdata[13:0]), 0);
         return;
      end
      want = expected_writes.pop_front();
      if (rsp_tdata[13:0] !== want.addr)
         report_mismatch("byte_address", 32'(rsp_tdata[13:0]), 32'(want.addr));
      if (rsp_tdata[21:14] !== want.mask)
         report_mismatch("pixel_byte", 32'(rsp_tdata[21:14]), 32'(want.mask));
      if (rsp_tdata[23:22] !== 2'b00)
         report_mismatch("tdata pad", 32'(rsp_tdata[23:22]), 0);
      if (rsp_tuser[0] !== want.inv)
         report_mismatch("invert_out", 32'(rsp_tuser[0]), 32'(want.inv));
      if (rsp_tuser[1] !== want.off)
         report_mismatch("off_screen", 32'(rsp_tuser[1]), 32'(want.off));
      if (rsp_tlast !== want.last)
         report_mismatch("last_in_row", 32'(rsp_tlast), 32'(want.last));
   endtask

   // watch both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            predict_row(req_tdata[16:0], req_tdata[25:17], req_tdata[33:26],
                        req_tdata[41:34], req_tuser[0], req_tuser[1]);
         if (rsp_tvalid && rsp_tready) check_write();
      end
      writes_pending <= expected_writes.size();
   end

endmodule

// File: test/tb_top.sv
// Testbench top for the rectangle row byte writer: stimulus, idling and verdict
`timescale 1ns / 100ps

module tb_top;

   localparam int SCREEN_WIDTH  = 320;
   localparam int SCREEN_HEIGHT = 240;
   localparam int DRAWN_ROWS    = 360;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   int          fail_count;
   int          writes_pending;
   bit          sender_steady = 1'b0;
   bit          sink_steady   = 1'b0;

   rect_row_to_mono_bytes #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   rrmb_checker #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .fail_count     (fail_count),
      .writes_pending (writes_pending)
   );

   // 10 ns clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #30_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // sender gap: mostly none, some short, a few long
   function automatic int pick_gap();
      int r;
      if (sender_steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 50);
   endfunction

   // offer one row request and hold it until accepted
   task automatic send_row(input logic [16:0] pos, input logic [8:0] span,
                           input logic [7:0] height, input logic [7:0] row,
                           input logic solid, input logic inv);
      int gap;
      gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_tvalid = 1'b0;
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = {6'd0, row, height, span, pos};
      req_tuser  = {inv, solid};
      do @(posedge clock); while (!req_tready);
   endtask

   // stop offering and wait until every predicted write has come back
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (writes_pending != 0) @(negedge clock);
   endtask

   // result side backpressure
   initial begin
      int r;
      int stall;
      rsp_tready = 1'b0;
      forever begin
         if (sink_steady) begin
            @(negedge clock);
            rsp_tready = 1'b1;
         end else begin
            repeat ($urandom_range(1, 20)) begin
               @(negedge clock);
               rsp_tready = 1'b1;
            end
            r     = $urandom_range(0, 99);
            stall = (r < 85) ? $urandom_range(1, 3) : $urandom_range(15, 40);
            repeat (stall) begin
               @(negedge clock);
               rsp_tready = 1'b0;
            end
         end
      end
   end

   // stimulus and verdict
   initial begin
      int          drawn;
      int          req_count;
      int          r;
      bit          pressure_done;
      logic [16:0] pos;
      logic [8:0]  span;
      logic [7:0]  height;
      logic [7:0]  row;
      logic        solid;
      logic        inv;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = '0;
      reset         = 1'b1;
      drawn         = 0;
      req_count     = 0;
      pressure_done = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty rectangles and rows outside
      send_row(17'd100, 9'd0, 8'd10, 8'd0, 1'b1, 1'b0);
      send_row(17'd100, 9'd10, 8'd0, 8'd0, 1'b1, 1'b1);
      send_row(17'd100, 9'd10, 8'd10, 8'd10, 1'b0, 1'b0);
      send_row(17'd100, 9'd10, 8'd255, 8'd255, 1'b1, 1'b0);
      send_row(17'd100, 9'd10, 8'd200, 8'd255, 1'b0, 1'b1);
      // directed: top, middle and bottom rows, outline and filled
      send_row(17'd0, 9'd320, 8'd240, 8'd0, 1'b0, 1'b0);
      send_row(17'd3, 9'd20, 8'd10, 8'd5, 1'b0, 1'b1);
      send_row(17'd3, 9'd20, 8'd10, 8'd5, 1'b1, 1'b0);
      send_row(17'd3, 9'd20, 8'd10, 8'd9, 1'b0, 1'b1);
      send_row(17'd100, 9'd10, 8'd255, 8'd254, 1'b0, 1'b0);
      // directed: widest row and saturated span
      send_row(17'd7, 9'd320, 8'd5, 8'd2, 1'b1, 1'b1);
      send_row(17'd1234, 9'd511, 8'd5, 8'd1, 1'b0, 1'b0);
      // directed: single byte cases and short rows over two or three bytes
      send_row(17'd5, 9'd1, 8'd3, 8'd1, 1'b0, 1'b1);
      send_row(17'd9, 9'd5, 8'd3, 8'd1, 1'b0, 1'b0);
      send_row(17'd16, 9'd8, 8'd3, 8'd1, 1'b1, 1'b1);
      send_row(17'd7, 9'd2, 8'd3, 8'd1, 1'b0, 1'b0);
      send_row(17'd0, 9'd9, 8'd4, 8'd2, 1'b0, 1'b1);
      send_row(17'd40, 9'd17, 8'd1, 8'd0, 1'b0, 1'b1);
      // directed: extremes of the start pixel and writes past the frame
      send_row(17'd76799, 9'd1, 8'd1, 8'd0, 1'b0, 1'b0);
      send_row(17'd76000, 9'd100, 8'd240, 8'd200, 1'b1, 1'b0);
      send_row(17'h1FFFF, 9'd511, 8'd240, 8'd239, 1'b1, 1'b1);
      wait_drained();

      // random rows, mostly drawable with random shape
      while (drawn < DRAWN_ROWS) begin
         if (req_count % 40 == 0) begin
            sender_steady = ($urandom_range(0, 3) == 0);
            sink_steady   = ($urandom_range(0, 3) == 0);
         end
         r     = $urandom_range(0, 99);
         solid = 1'($urandom_range(0, 1));
         inv   = 1'($urandom_range(0, 1));
         if (r < 12) begin
            // noise over the whole field widths
            pos    = 17'($urandom_range(0, 17'h1FFFF));
            span   = 9'($urandom_range(0, 511));
            height = 8'($urandom_range(0, 255));
            row    = 8'($urandom_range(0, 255));
         end else begin
            pos    = ($urandom_range(0, 19) == 0) ? 17'($urandom_range(0, 17'h1FFFF))
                                                  : 17'($urandom_range(0, 76799));
            height = 8'($urandom_range(1, 240));
            r      = $urandom_range(0, 99);
            if (r < 70) span = 9'($urandom_range(1, 40));
            else if (r < 92) span = 9'($urandom_range(41, 320));
            else span = 9'($urandom_range(321, 511));
            r = $urandom_range(0, 3);
            if (r == 0) row = 8'd0;
            else if (r == 1) row = height - 8'd1;
            else row = 8'($urandom_range(0, height - 1));
         end
         send_row(pos, span, height, row, solid, inv);
         req_count++;
         if (span != 0 && height != 0 && row < height) drawn++;
         // let the pipeline run dry once mid-run
         if (drawn >= DRAWN_ROWS / 2 && !pressure_done) begin
            pressure_done = 1'b1;
            wait_drained();
            repeat ($urandom_range(5, 20)) @(negedge clock);
         end
      end

      @(negedge clock);
      req_tvalid = 1'b0;
      wait_drained();
      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// File: filelist.f
design/rrmb_pkg.sv
design/rrmb_front.sv
design/rrmb_queue.sv
design/rrmb_back.sv
design/rect_row_to_mono_bytes.sv
test/rrmb_checker.sv
test/tb_top.sv
